### rtl/ccvr_pkg.sv
package ccvr_pkg;

  // quotient bits produced by the divider, one per stage after the entry stage
  localparam int QW = 41;
  localparam int DIV_STAGES = QW + 1;
  // pipeline depth from input beat to output register
  localparam int LAT = 11 + DIV_STAGES + 1;
  // divider operand widths
  localparam int N2_W = 152;
  localparam int D2_W = 116;
  localparam int CMP_W = D2_W + QW;
  // numerator magnitude width and partial product chunking
  localparam int NUM_W = 150;
  localparam int NUM_SUM_W = 153;
  localparam int PP_CHUNK = 30;
  localparam int LANES = 4;

  localparam int ELAST_W = 17;
  localparam logic [ELAST_W-1:0] ELAST_RESET = 17'd65536;

  // largest velocity change magnitude, 2^40
  localparam logic [QW-1:0] CLAMP_MAG = {1'b1, {(QW-1){1'b0}}};

  // quotient lane result
  typedef struct packed {
    logic [QW-1:0] q;
    logic          ovf;
    logic          neg;
  } div_res_t;

  // data that rides along the pipeline
  typedef struct packed {
    logic signed [31:0] v1x;
    logic signed [31:0] v1y;
    logic signed [31:0] v2x;
    logic signed [31:0] v2y;
    logic               upd1;
    logic               upd2;
    logic               degen;
  } side_t;

endpackage

### rtl/ccvr_div.sv
module ccvr_div (
  input  logic                         clk,
  input  logic                         en,
  input  logic [ccvr_pkg::N2_W-1:0]    n2,
  input  logic [ccvr_pkg::D2_W-1:0]    d2,
  input  logic                         neg,
  output ccvr_pkg::div_res_t           res
);

  logic [ccvr_pkg::D2_W-1:0] rem_q [ccvr_pkg::QW+1];
  logic [ccvr_pkg::D2_W-1:0] den_q [ccvr_pkg::QW+1];
  logic [ccvr_pkg::QW-1:0]   nlo_q [ccvr_pkg::QW+1];
  logic [ccvr_pkg::QW-1:0]   quo_q [ccvr_pkg::QW+1];
  logic                      ovf_q [ccvr_pkg::QW+1];
  logic                      neg_q [ccvr_pkg::QW+1];

  logic [ccvr_pkg::D2_W:0]   trial   [ccvr_pkg::QW+1];
  logic [ccvr_pkg::D2_W-1:0] rem_next [ccvr_pkg::QW+1];
  logic                      qbit    [ccvr_pkg::QW+1];

  // one restoring step per stage
  always_comb begin
    for (int k = 0; k <= ccvr_pkg::QW; k++) begin
      trial[k]    = {rem_q[k], nlo_q[k][ccvr_pkg::QW-1]};
      qbit[k]     = (trial[k] >= {1'b0, den_q[k]});
      rem_next[k] = qbit[k] ? ccvr_pkg::D2_W'(trial[k] - {1'b0, den_q[k]})
                            : ccvr_pkg::D2_W'(trial[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // entry stage: overflow check and initial remainder
      rem_q[0] <= ccvr_pkg::D2_W'(n2 >> ccvr_pkg::QW);
      nlo_q[0] <= n2[ccvr_pkg::QW-1:0];
      den_q[0] <= d2;
      quo_q[0] <= '0;
      ovf_q[0] <= (ccvr_pkg::CMP_W'(n2) >= {d2, {ccvr_pkg::QW{1'b0}}});
      neg_q[0] <= neg;
      for (int k = 1; k <= ccvr_pkg::QW; k++) begin
        rem_q[k] <= rem_next[k-1];
        nlo_q[k] <= nlo_q[k-1] << 1;
        den_q[k] <= den_q[k-1];
        quo_q[k] <= {quo_q[k-1][ccvr_pkg::QW-2:0], qbit[k-1]};
        ovf_q[k] <= ovf_q[k-1];
        neg_q[k] <= neg_q[k-1];
      end
    end
  end

  assign res.q   = quo_q[ccvr_pkg::QW];
  assign res.ovf = ovf_q[ccvr_pkg::QW];
  assign res.neg = neg_q[ccvr_pkg::QW];

endmodule

### rtl/circle_collision_velocity_resolve.sv
// Velocity resolution for one colliding pair of circles.
// Input channel: in_valid / in_ready carry one pair per beat (positions,
// velocities, masses, fixed flags). Output channel: out_valid / out_ready
// carry the new velocities, the write-back flags and the degenerate flag.
// elasticity_we / elasticity_wdata write the restitution factor; write it
// only while no beat is in flight.
// One pair is accepted per cycle while the output is not stalled.
// The depth is set by the restoring divider, which produces one of 41
// quotient bits per stage, after eleven stages of multiply and add that
// build the operands.
// The four velocity components share the same divisor and run in four
// parallel divider lanes.
// Reset clears all valid bits and sets elasticity to 1.0.
// When the receiver stalls, the whole pipeline holds and in_ready drops;
// nothing is lost or repeated.
module circle_collision_velocity_resolve (
  input  logic                clk,
  input  logic                rst,
  input  logic                elasticity_we,
  input  logic [16:0]         elasticity_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [31:0]  first_pos_x,
  input  logic signed [31:0]  first_pos_y,
  input  logic signed [31:0]  second_pos_x,
  input  logic signed [31:0]  second_pos_y,
  input  logic signed [31:0]  first_vel_x,
  input  logic signed [31:0]  first_vel_y,
  input  logic signed [31:0]  second_vel_x,
  input  logic signed [31:0]  second_vel_y,
  input  logic [31:0]         first_mass,
  input  logic [31:0]         second_mass,
  input  logic                first_fixed,
  input  logic                second_fixed,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [31:0]  new_first_vel_x,
  output logic signed [31:0]  new_first_vel_y,
  output logic signed [31:0]  new_second_vel_x,
  output logic signed [31:0]  new_second_vel_y,
  output logic                first_updated,
  output logic                second_updated,
  output logic                degenerate
);

  logic                             en;
  logic [ccvr_pkg::ELAST_W-1:0]     elasticity;
  logic [ccvr_pkg::LAT-1:0]         valid_q;
  ccvr_pkg::side_t                  side_q [ccvr_pkg::LAT-1];
  ccvr_pkg::side_t                  side_in;
  ccvr_pkg::side_t                  side_f;

  logic signed [32:0] dx_c, dy_c;
  logic [32:0]        msum_c;
  logic               both_c, deg_c;

  logic signed [32:0] s1_dx, s1_dy, s1_dm;
  logic [32:0]        s1_m, s1_m1x2, s1_m2x2;

  logic signed [65:0] s2_p1x, s2_p1y, s2_p2x, s2_p2y, s2_pxx, s2_pyy;
  logic signed [32:0] s2_dx, s2_dy, s2_dm;
  logic [32:0]        s2_m, s2_m1x2, s2_m2x2;

  logic signed [65:0] s3_t1, s3_t2;
  logic [65:0]        s3_d;
  logic signed [32:0] s3_dx, s3_dy, s3_dm;
  logic [32:0]        s3_m, s3_m1x2, s3_m2x2;

  logic signed [67:0] s4_al1, s4_ah1, s4_bl2, s4_bh2;
  logic signed [67:0] s4_cl1, s4_ch1, s4_gl2, s4_gh2;
  logic signed [67:0] s4_pl1, s4_ph1, s4_pl2, s4_ph2;
  logic [65:0]        s4_mdl, s4_mdh;
  logic signed [32:0] s4_dx, s4_dy;

  logic signed [100:0] s5_a1, s5_a2;
  logic signed [99:0]  s5_p1, s5_p2;
  logic [98:0]         s5_md;
  logic signed [32:0]  s5_dx, s5_dy;

  logic signed [69:0]  s6_el1, s6_eh1, s6_el2, s6_eh2;
  logic signed [99:0]  s6_p1, s6_p2;
  logic [98:0]         s6_md;
  logic signed [32:0]  s6_dx, s6_dy;

  logic signed [118:0] s7_n1, s7_n2;
  logic [98:0]         s7_md;
  logic signed [32:0]  s7_dx, s7_dy;

  logic [32:0]         s8_ad [2];
  logic [119:0]        s8_an [2];
  logic                s8_sd [2];
  logic                s8_sn [2];
  logic [98:0]         s8_md;

  logic [62:0]         s9_pp  [ccvr_pkg::LANES][4];
  logic                s9_neg [ccvr_pkg::LANES];
  logic [98:0]         s9_md;

  logic [ccvr_pkg::NUM_SUM_W-1:0] num_c [ccvr_pkg::LANES];
  logic [ccvr_pkg::NUM_W-1:0]     s10_num [ccvr_pkg::LANES];
  logic                           s10_neg [ccvr_pkg::LANES];
  logic [ccvr_pkg::D2_W-2:0]      s10_den;

  logic [ccvr_pkg::N2_W-1:0]      s11_n2  [ccvr_pkg::LANES];
  logic                           s11_neg [ccvr_pkg::LANES];
  logic [ccvr_pkg::D2_W-1:0]      s11_d2;

  ccvr_pkg::div_res_t             dres [ccvr_pkg::LANES];

  // global advance: hold everything while the output beat waits
  assign en       = !valid_q[ccvr_pkg::LAT-1] || out_ready;
  assign in_ready = en;

  // saturating add of the signed, clamped change
  function automatic logic signed [31:0] sat_add(input logic signed [31:0] v,
                                                 input ccvr_pkg::div_res_t r);
    logic [ccvr_pkg::QW-1:0]   mag;
    logic signed [ccvr_pkg::QW:0] delta;
    logic signed [42:0]        sum;
    mag   = (r.ovf || r.q > ccvr_pkg::CLAMP_MAG) ? ccvr_pkg::CLAMP_MAG : r.q;
    delta = r.neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    sum   = 43'(v) + 43'(delta);
    if (sum > 43'sd2147483647) begin
      sat_add = 32'sh7fffffff;
    end else if (sum < -43'sd2147483648) begin
      sat_add = 32'sh80000000;
    end else begin
      sat_add = sum[31:0];
    end
  endfunction

  // front-end differences and special cases
  always_comb begin
    dx_c   = 33'(second_pos_x) - 33'(first_pos_x);
    dy_c   = 33'(second_pos_y) - 33'(first_pos_y);
    msum_c = {1'b0, first_mass} + {1'b0, second_mass};
    both_c = first_fixed && second_fixed;
    deg_c  = !both_c && (((dx_c == '0) && (dy_c == '0)) || (msum_c == '0));
    side_in.v1x   = first_vel_x;
    side_in.v1y   = first_vel_y;
    side_in.v2x   = second_vel_x;
    side_in.v2y   = second_vel_y;
    side_in.degen = deg_c;
    side_in.upd1  = !both_c && !deg_c && !first_fixed;
    side_in.upd2  = !both_c && !deg_c && !second_fixed;
  end

  // control: valid line and elasticity register
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q    <= '0;
      elasticity <= ccvr_pkg::ELAST_RESET;
    end else begin
      if (elasticity_we) begin
        elasticity <= elasticity_wdata;
      end
      if (en) begin
        valid_q <= {valid_q[ccvr_pkg::LAT-2:0], in_valid};
      end
    end
  end

  // side data line
  always_ff @(posedge clk) begin
    if (en) begin
      side_q[0] <= side_in;
      for (int k = 1; k < ccvr_pkg::LAT-1; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  // stages 1 to 3: differences, dot products, squared distance
  always_ff @(posedge clk) begin
    if (en) begin
      s1_dx   <= dx_c;
      s1_dy   <= dy_c;
      s1_dm   <= $signed({1'b0, first_mass}) - $signed({1'b0, second_mass});
      s1_m    <= msum_c;
      s1_m1x2 <= {first_mass, 1'b0};
      s1_m2x2 <= {second_mass, 1'b0};

      s2_p1x  <= s1_dx * side_q[0].v1x;
      s2_p1y  <= s1_dy * side_q[0].v1y;
      s2_p2x  <= s1_dx * side_q[0].v2x;
      s2_p2y  <= s1_dy * side_q[0].v2y;
      s2_pxx  <= s1_dx * s1_dx;
      s2_pyy  <= s1_dy * s1_dy;
      s2_dx   <= s1_dx;
      s2_dy   <= s1_dy;
      s2_dm   <= s1_dm;
      s2_m    <= s1_m;
      s2_m1x2 <= s1_m1x2;
      s2_m2x2 <= s1_m2x2;

      s3_t1   <= s2_p1x + s2_p1y;
      s3_t2   <= s2_p2x + s2_p2y;
      s3_d    <= s2_pxx[65:0] + s2_pyy[65:0];
      s3_dx   <= s2_dx;
      s3_dy   <= s2_dy;
      s3_dm   <= s2_dm;
      s3_m    <= s2_m;
      s3_m1x2 <= s2_m1x2;
      s3_m2x2 <= s2_m2x2;
    end
  end

  // stages 4 and 5: mass products split into halves, then summed
  always_ff @(posedge clk) begin
    if (en) begin
      s4_al1 <= s3_dm * $signed({1'b0, s3_t1[32:0]});
      s4_ah1 <= s3_dm * $signed(s3_t1[65:33]);
      s4_bl2 <= $signed({1'b0, s3_m2x2}) * $signed({1'b0, s3_t2[32:0]});
      s4_bh2 <= $signed({1'b0, s3_m2x2}) * $signed(s3_t2[65:33]);
      s4_cl1 <= $signed({1'b0, s3_m1x2}) * $signed({1'b0, s3_t1[32:0]});
      s4_ch1 <= $signed({1'b0, s3_m1x2}) * $signed(s3_t1[65:33]);
      s4_gl2 <= s3_dm * $signed({1'b0, s3_t2[32:0]});
      s4_gh2 <= s3_dm * $signed(s3_t2[65:33]);
      s4_pl1 <= $signed({1'b0, s3_m}) * $signed({1'b0, s3_t1[32:0]});
      s4_ph1 <= $signed({1'b0, s3_m}) * $signed(s3_t1[65:33]);
      s4_pl2 <= $signed({1'b0, s3_m}) * $signed({1'b0, s3_t2[32:0]});
      s4_ph2 <= $signed({1'b0, s3_m}) * $signed(s3_t2[65:33]);
      s4_mdl <= s3_m * s3_d[32:0];
      s4_mdh <= s3_m * s3_d[65:33];
      s4_dx  <= s3_dx;
      s4_dy  <= s3_dy;

      s5_a1 <= (s4_ah1 <<< 33) + s4_al1 + (s4_bh2 <<< 33) + s4_bl2;
      s5_a2 <= (s4_ch1 <<< 33) + s4_cl1 - (s4_gh2 <<< 33) - s4_gl2;
      s5_p1 <= (s4_ph1 <<< 33) + s4_pl1;
      s5_p2 <= (s4_ph2 <<< 33) + s4_pl2;
      s5_md <= (99'(s4_mdh) << 33) + 99'(s4_mdl);
      s5_dx <= s4_dx;
      s5_dy <= s4_dy;
    end
  end

  // stages 6 to 8: restitution scaling, normal numerator, magnitudes
  always_ff @(posedge clk) begin
    if (en) begin
      s6_el1 <= $signed({1'b0, elasticity}) * $signed({1'b0, s5_a1[50:0]});
      s6_eh1 <= $signed({1'b0, elasticity}) * $signed(s5_a1[100:51]);
      s6_el2 <= $signed({1'b0, elasticity}) * $signed({1'b0, s5_a2[50:0]});
      s6_eh2 <= $signed({1'b0, elasticity}) * $signed(s5_a2[100:51]);
      s6_p1  <= s5_p1;
      s6_p2  <= s5_p2;
      s6_md  <= s5_md;
      s6_dx  <= s5_dx;
      s6_dy  <= s5_dy;

      s7_n1 <= (s6_eh1 <<< 51) + s6_el1 - (s6_p1 <<< 16);
      s7_n2 <= (s6_eh2 <<< 51) + s6_el2 - (s6_p2 <<< 16);
      s7_md <= s6_md;
      s7_dx <= s6_dx;
      s7_dy <= s6_dy;

      s8_ad[0] <= s7_dx[32] ? 33'(-s7_dx) : 33'(s7_dx);
      s8_ad[1] <= s7_dy[32] ? 33'(-s7_dy) : 33'(s7_dy);
      s8_an[0] <= s7_n1[118] ? 120'(-s7_n1) : 120'(s7_n1);
      s8_an[1] <= s7_n2[118] ? 120'(-s7_n2) : 120'(s7_n2);
      s8_sd[0] <= s7_dx[32];
      s8_sd[1] <= s7_dy[32];
      s8_sn[0] <= s7_n1[118];
      s8_sn[1] <= s7_n2[118];
      s8_md    <= s7_md;
    end
  end

  // numerator partial sums per lane
  always_comb begin
    for (int l = 0; l < ccvr_pkg::LANES; l++) begin
      num_c[l] = '0;
      for (int c = 0; c < 4; c++) begin
        num_c[l] = num_c[l] +
                   (ccvr_pkg::NUM_SUM_W'(s9_pp[l][c]) << (ccvr_pkg::PP_CHUNK * c));
      end
    end
  end

  // stages 9 to 11: lane numerators and divider operands
  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < ccvr_pkg::LANES; l++) begin
        for (int c = 0; c < 4; c++) begin
          s9_pp[l][c] <= s8_ad[1'(l)] *
                         s8_an[1'(l >> 1)][ccvr_pkg::PP_CHUNK*c +: ccvr_pkg::PP_CHUNK];
        end
        s9_neg[l]  <= s8_sd[1'(l)] ^ s8_sn[1'(l >> 1)];
        s10_num[l] <= num_c[l][ccvr_pkg::NUM_W-1:0];
        s10_neg[l] <= s9_neg[l];
        s11_n2[l]  <= ccvr_pkg::N2_W'({s10_num[l], 1'b0}) + ccvr_pkg::N2_W'(s10_den);
        s11_neg[l] <= s10_neg[l];
      end
      s9_md   <= s8_md;
      s10_den <= {s9_md, 16'd0};
      s11_d2  <= {s10_den, 1'b0};
    end
  end

  // four divider lanes: first x, first y, second x, second y
  for (genvar g = 0; g < ccvr_pkg::LANES; g++) begin : g_div
    ccvr_div u_div (
      .clk (clk),
      .en  (en),
      .n2  (s11_n2[g]),
      .d2  (s11_d2),
      .neg (s11_neg[g]),
      .res (dres[g])
    );
  end

  assign side_f = side_q[ccvr_pkg::LAT-2];

  // output register
  always_ff @(posedge clk) begin
    if (en) begin
      new_first_vel_x  <= side_f.upd1 ? sat_add(side_f.v1x, dres[0]) : side_f.v1x;
      new_first_vel_y  <= side_f.upd1 ? sat_add(side_f.v1y, dres[1]) : side_f.v1y;
      new_second_vel_x <= side_f.upd2 ? sat_add(side_f.v2x, dres[2]) : side_f.v2x;
      new_second_vel_y <= side_f.upd2 ? sat_add(side_f.v2y, dres[3]) : side_f.v2y;
      first_updated    <= side_f.upd1;
      second_updated   <= side_f.upd2;
      degenerate       <= side_f.degen;
    end
  end

  assign out_valid = valid_q[ccvr_pkg::LAT-1];

`ifndef SYNTHESIS
  // a degenerate pair never asks for a write-back
  a_degen_no_update: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> !first_updated && !second_updated)
    else $error("degenerate pair flagged for update");

  // a stall freezes every valid bit in the pipeline
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(valid_q))
    else $error("pipeline moved during stall");
`endif

endmodule

### tb/circle_collision_velocity_resolve_tb.sv
`timescale 1ns / 100ps

module circle_collision_velocity_resolve_tb;

  typedef struct {
    logic signed [31:0] p1x, p1y, p2x, p2y;
    logic signed [31:0] v1x, v1y, v2x, v2y;
    logic [31:0]        m1, m2;
    logic               f1, f2;
  } pair_t;

  typedef struct {
    logic signed [31:0] v1x, v1y, v2x, v2y;
    logic               upd1, upd2, degen;
  } velocities_t;

  localparam logic [ccvr_pkg::ELAST_W-1:0] E_ONE = 17'd65536;
  localparam logic [ccvr_pkg::ELAST_W-1:0] E_MAX = 17'h1FFFF;
  localparam logic [ccvr_pkg::ELAST_W-1:0] E_ZERO = 17'd0;
  localparam int DRAIN_LIMIT = 4000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic elasticity_we = 1'b0;
  logic [16:0] elasticity_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] first_pos_x = '0, first_pos_y = '0, second_pos_x = '0, second_pos_y = '0;
  logic signed [31:0] first_vel_x = '0, first_vel_y = '0, second_vel_x = '0, second_vel_y = '0;
  logic [31:0] first_mass = '0, second_mass = '0;
  logic first_fixed = 1'b0, second_fixed = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] new_first_vel_x, new_first_vel_y, new_second_vel_x, new_second_vel_y;
  logic first_updated, second_updated, degenerate;

  // model copy of the restitution register
  logic [ccvr_pkg::ELAST_W-1:0] restitution = ccvr_pkg::ELAST_RESET;
  velocities_t expected_velocities[$];
  int errors = 0;
  int pairs_sent = 0;
  int results_seen = 0;
  int degenerate_seen = 0;
  bit no_gaps = 1'b0;

  circle_collision_velocity_resolve u_dut (
    .clk(clk), .rst(rst),
    .elasticity_we(elasticity_we), .elasticity_wdata(elasticity_wdata),
    .in_valid(in_valid), .in_ready(in_ready),
    .first_pos_x(first_pos_x), .first_pos_y(first_pos_y),
    .second_pos_x(second_pos_x), .second_pos_y(second_pos_y),
    .first_vel_x(first_vel_x), .first_vel_y(first_vel_y),
    .second_vel_x(second_vel_x), .second_vel_y(second_vel_y),
    .first_mass(first_mass), .second_mass(second_mass),
    .first_fixed(first_fixed), .second_fixed(second_fixed),
    .out_valid(out_valid), .out_ready(out_ready),
    .new_first_vel_x(new_first_vel_x), .new_first_vel_y(new_first_vel_y),
    .new_second_vel_x(new_second_vel_x), .new_second_vel_y(new_second_vel_y),
    .first_updated(first_updated), .second_updated(second_updated),
    .degenerate(degenerate)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // velocity change, rounded half away from zero, magnitude clamped to 2^40
  function automatic logic signed [63:0] rounded_delta(logic signed [255:0] num,
                                                       logic signed [255:0] den);
    logic [255:0] mag;
    logic [255:0] q;
    mag = num < 0 ? -num : num;
    q = (2 * mag + den) / (2 * den);
    if (q > (256'd1 << 40)) q = 256'd1 << 40;
    return num < 0 ? -$signed(q[63:0]) : $signed(q[63:0]);
  endfunction

  function automatic logic signed [31:0] sat32(logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // exact collision response along the line of centres
  function automatic velocities_t resolve_collision(pair_t p,
                                                    logic [ccvr_pkg::ELAST_W-1:0] e);
    velocities_t r;
    logic signed [255:0] a, b, dx, dy, v1x, v1y, v2x, v2y, m1, m2;
    logic signed [255:0] t1, t2, dd, mm, a1, a2, n1, n2, den, ev;
    logic signed [63:0] w1, w2;
    r.v1x = p.v1x; r.v1y = p.v1y; r.v2x = p.v2x; r.v2y = p.v2y;
    r.upd1 = 1'b0; r.upd2 = 1'b0; r.degen = 1'b0;
    if (p.f1 && p.f2) return r;
    a = p.p1x; b = p.p2x; dx = b - a;
    a = p.p1y; b = p.p2y; dy = b - a;
    m1 = {224'd0, p.m1};
    m2 = {224'd0, p.m2};
    if ((dx == 0 && dy == 0) || (m1 + m2) == 0) begin
      r.degen = 1'b1;
      return r;
    end
    v1x = p.v1x; v1y = p.v1y; v2x = p.v2x; v2y = p.v2y;
    ev = {239'd0, e};
    t1 = dx * v1x + dy * v1y;
    t2 = dx * v2x + dy * v2y;
    dd = dx * dx + dy * dy;
    mm = (m1 + m2) * 65536;
    a1 = (m1 - m2) * t1 + 2 * m2 * t2;
    a2 = (m2 - m1) * t2 + 2 * m1 * t1;
    n1 = ev * a1 - mm * t1;
    n2 = ev * a2 - mm * t2;
    den = mm * dd;
    if (!p.f1) begin
      w1 = p.v1x; w2 = p.v1y;
      r.v1x = sat32(w1 + rounded_delta(dx * n1, den));
      r.v1y = sat32(w2 + rounded_delta(dy * n1, den));
      r.upd1 = 1'b1;
    end
    if (!p.f2) begin
      w1 = p.v2x; w2 = p.v2y;
      r.v2x = sat32(w1 + rounded_delta(dx * n2, den));
      r.v2y = sat32(w2 + rounded_delta(dy * n2, den));
      r.upd2 = 1'b1;
    end
    return r;
  endfunction

  // sends a pair, holds it until accepted; called in step with the clock
  task automatic send_pair(pair_t p);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    first_pos_x <= p.p1x; first_pos_y <= p.p1y;
    second_pos_x <= p.p2x; second_pos_y <= p.p2y;
    first_vel_x <= p.v1x; first_vel_y <= p.v1y;
    second_vel_x <= p.v2x; second_vel_y <= p.v2y;
    first_mass <= p.m1; second_mass <= p.m2;
    first_fixed <= p.f1; second_fixed <= p.f2;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    expected_velocities.push_back(resolve_collision(p, restitution));
    pairs_sent++;
  endtask

  // wait for every result, then let the pipeline run dry
  task automatic drain();
    int n;
    n = 0;
    in_valid <= 1'b0;
    while (expected_velocities.size() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
    repeat (ccvr_pkg::LAT + 8) @(posedge clk);
  endtask

  task automatic write_restitution(logic [ccvr_pkg::ELAST_W-1:0] e);
    drain();
    elasticity_we <= 1'b1;
    elasticity_wdata <= e;
    @(posedge clk);
    elasticity_we <= 1'b0;
    restitution = e;
  endtask

  function automatic logic signed [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'sh7FFFFFFF;
      2: return 32'sh80000000;
      3: return 32'sd0;
      default: return $signed($urandom_range(0, 32'h3FFFFF)) - 32'sh200000;
    endcase
  endfunction

  function automatic logic [31:0] rand_mass();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'hFFFFFFFF;
      2: return 32'd0;
      default: return $urandom_range(1, 32'h0FFFFF);
    endcase
  endfunction

  function automatic pair_t rand_pair();
    pair_t p;
    p.p1x = rand_word(); p.p1y = rand_word();
    p.p2x = rand_word(); p.p2y = rand_word();
    p.v1x = rand_word(); p.v1y = rand_word();
    p.v2x = rand_word(); p.v2y = rand_word();
    p.m1 = rand_mass(); p.m2 = rand_mass();
    p.f1 = ($urandom_range(0, 5) == 0);
    p.f2 = ($urandom_range(0, 5) == 0);
    // occasional coincident centres
    if ($urandom_range(0, 19) == 0) begin
      p.p2x = p.p1x; p.p2y = p.p1y;
    end
    return p;
  endfunction

  function automatic pair_t make_pair(int p1x, int p1y, int p2x, int p2y, int v1x, int v1y,
                                      int v2x, int v2y, int m1, int m2, bit f1, bit f2);
    pair_t p;
    p.p1x = p1x; p.p1y = p1y; p.p2x = p2x; p.p2y = p2y;
    p.v1x = v1x; p.v1y = v1y; p.v2x = v2x; p.v2y = v2y;
    p.m1 = m1; p.m2 = m2; p.f1 = f1; p.f2 = f2;
    return p;
  endfunction

  // head-on, equal and unequal masses, fixed bodies
  task automatic test_basic_collisions();
    send_pair(make_pair(0, 0, 65536, 0, 65536, 0, -65536, 0, 65536, 65536, 0, 0));
    send_pair(make_pair(0, 0, 65536, 65536, 131072, 0, 0, 0, 65536, 196608, 0, 0));
    send_pair(make_pair(0, 0, 0, 65536, 0, 65536, 30000, -500, 65536, 65536, 1, 0));
    send_pair(make_pair(0, 0, 0, 65536, 0, 65536, 30000, -500, 65536, 65536, 0, 1));
    send_pair(make_pair(0, 0, 0, 65536, 0, 65536, 30000, -500, 65536, 65536, 1, 1));
    send_pair(make_pair(100, 7, -3, 9, 1000, -2000, 5, 77, 0, 65536, 0, 0));
  endtask

  // coincident centres, zero total mass, both fixed over a degenerate pair
  task automatic test_degenerate_pairs();
    send_pair(make_pair(12345, -6789, 12345, -6789, 1, 2, 3, 4, 65536, 65536, 0, 0));
    send_pair(make_pair(0, 0, 65536, 0, 70000, 1, -5, 9, 0, 0, 0, 0));
    send_pair(make_pair(5, 5, 5, 5, 70000, 1, -5, 9, 0, 0, 1, 1));
    send_pair(make_pair(0, 0, 65536, 0, 70000, 1, -5, 9, 0, 0, 0, 1));
  endtask

  // field extremes, saturation and clamping
  task automatic test_field_extremes();
    send_pair(make_pair(32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF,
                        32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h80000000,
                        32'hFFFFFFFF, 32'hFFFFFFFF, 0, 0));
    send_pair(make_pair(32'h7FFFFFFF, 0, 32'h80000000, 0, 32'h80000000, 32'h7FFFFFFF,
                        32'h7FFFFFFF, 32'h80000000, 1, 32'hFFFFFFFF, 0, 0));
    send_pair(make_pair(0, 0, 1, 0, 32'h7FFFFFFF, 0, 32'h80000000, 0,
                        32'hFFFFFFFF, 1, 0, 0));
    send_pair(make_pair(0, 0, 0, 1, 0, 32'h80000000, 0, 32'h7FFFFFFF, 1, 1, 0, 0));
    send_pair(make_pair(-1, -1, 1, 1, -1, 1, 1, -1, 32'hFFFFFFFF, 0, 0, 0));
  endtask

  task automatic test_random_pairs(int count);
    repeat (count) begin
      if ($urandom_range(0, 49) == 0) no_gaps = ~no_gaps;
      send_pair(rand_pair());
    end
    no_gaps = 1'b0;
  endtask

  // sender holds off until the pipeline is empty, then resumes
  task automatic test_hold_off();
    test_random_pairs(20);
    drain();
    test_random_pairs(20);
  endtask

  // results are checked in order against the oldest expectation
  always @(posedge clk) begin
    velocities_t x;
    if (!rst && out_valid && out_ready) begin
      if (expected_velocities.size() == 0) begin
        $error("result beat with no pair outstanding");
        errors++;
      end else begin
        x = expected_velocities.pop_front();
        results_seen++;
        if (x.degen) degenerate_seen++;
        if (new_first_vel_x !== x.v1x) begin
          $error("new_first_vel_x exp %0d got %0d", x.v1x, new_first_vel_x); errors++;
        end
        if (new_first_vel_y !== x.v1y) begin
          $error("new_first_vel_y exp %0d got %0d", x.v1y, new_first_vel_y); errors++;
        end
        if (new_second_vel_x !== x.v2x) begin
          $error("new_second_vel_x exp %0d got %0d", x.v2x, new_second_vel_x); errors++;
        end
        if (new_second_vel_y !== x.v2y) begin
          $error("new_second_vel_y exp %0d got %0d", x.v2y, new_second_vel_y); errors++;
        end
        if (first_updated !== x.upd1) begin
          $error("first_updated exp %0b got %0b", x.upd1, first_updated); errors++;
        end
        if (second_updated !== x.upd2) begin
          $error("second_updated exp %0b got %0b", x.upd2, second_updated); errors++;
        end
        if (degenerate !== x.degen) begin
          $error("degenerate exp %0b got %0b", x.degen, degenerate); errors++;
        end
      end
    end
  end

  // receiver randomly withholds out_ready before each result beat
  initial begin
    int stall;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = $urandom_range(0, 4);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    #400000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_basic_collisions();
    test_degenerate_pairs();
    test_field_extremes();
    write_restitution(E_ZERO);
    test_basic_collisions();
    test_field_extremes();
    write_restitution(E_MAX);
    test_basic_collisions();
    test_field_extremes();
    write_restitution(17'd32768);
    test_random_pairs(300);
    write_restitution(E_ONE);
    test_random_pairs(300);
    test_hold_off();
    write_restitution(17'($urandom_range(0, 65536)));
    test_random_pairs(250);
    drain();
    if (expected_velocities.size() != 0) begin
      $error("%0d results never arrived", expected_velocities.size());
      errors++;
    end
    $display("sent %0d pairs, checked %0d results (%0d degenerate)",
             pairs_sent, results_seen, degenerate_seen);
    $display("restitution swept over zero, half, one and the register maximum");
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/ccvr_pkg.sv
rtl/ccvr_div.sv
rtl/circle_collision_velocity_resolve.sv
tb/circle_collision_velocity_resolve_tb.sv
